// ===== sv/idmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the integer divide / modulo / power unit.
// No dependencies.
package idmp_pkg;

  // Arithmetic width; operands use their low DATA_WIDTH bits (8 to 64).
  localparam int DATA_WIDTH = 64;
  // Width of the operand and result fields on the ports.
  localparam int OPND_W     = 64;
  // Split point for the 64-bit wrapped multiply on a half-width multiplier.
  localparam int HALF_W     = (DATA_WIDTH + 1) / 2;
  // Divider iteration counter width.
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    OP_QUO = 2'd0,
    OP_REM = 2'd1,
    OP_MOD = 2'd2,
    OP_POW = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_NEGEXP  = 2'd2
  } status_e;

endpackage

// ===== sv/idmp_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: opcode and two signed operands, valid/ready handshake.
// Depends on idmp_pkg.
interface idmp_in_if
  import idmp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  opcode_e                  opcode;
  logic signed [OPND_W-1:0] operand_a;
  logic signed [OPND_W-1:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

// ===== sv/idmp_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: result value and status, valid/ready handshake.
// Depends on idmp_pkg.
interface idmp_out_if
  import idmp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [OPND_W-1:0] result_value;
  status_e                  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== sv/int_divide_modulo_power_unit.sv =====
`timescale 1ns / 1ps
// Signed integer divide / remainder / modulo / power unit, top level.
// Depends on idmp_pkg, idmp_in_if, idmp_out_if, idmp_div_core, idmp_mul_core.
//
// One beat in, one beat out. Opcode QUO truncates toward zero (most negative
// by -1 wraps), REM takes the dividend's sign, MOD the divisor's sign, POW is
// square-and-multiply wrapped to DATA_WIDTH bits. A zero divisor gives status
// DIVZERO and a negative exponent gives NEGEXP, both with a zero result.
// The unit works on one beat at a time: in.ready is high only while idle.
// Divide ops run on the one-bit-per-cycle restoring divider; zero-divisor and
// negative-exponent beats skip it and go straight to the result. POW runs a
// multiply for each set bit of the exponent and a squaring for each shift that
// leaves a nonzero exponent; each wrapped multiply takes four steps on the
// shared half-width multiplier before the product is handed back. A finished
// result sits in an output register, so the next beat is taken while it waits.

module int_divide_modulo_power_unit
  import idmp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  idmp_in_if.sink    in_i,
  idmp_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_NEG,
    S_FIX,
    S_PCHK,
    S_PMUL,
    S_PSHIFT,
    S_PSQR,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  opcode_e op_q, op_d;
  status_e st_q, st_d;
  logic    sa_q, sa_d;
  logic    sb_q, sb_d;
  logic    rnz_q, rnz_d;
  data_t   b_q, b_d;
  data_t   res_q, res_d;
  data_t   expo_q, expo_d;
  data_t   pacc_q, pacc_d;
  data_t   fac_q, fac_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [OPND_W-1:0] out_res_q, out_res_d;
  status_e                  out_st_q, out_st_d;

  logic  in_acc;
  data_t a_in, b_in;
  data_t a_mag, b_mag;
  logic  div_start, div_done;
  data_t div_quo, div_rem;
  logic  mul_start, mul_done;
  data_t mul_a, mul_prod;
  data_t expo_shr;
  logic  neg_res;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Only the low DATA_WIDTH bits of each operand count.
  assign a_in  = in_i.operand_a[DATA_WIDTH-1:0];
  assign b_in  = in_i.operand_b[DATA_WIDTH-1:0];
  assign a_mag = a_in[DATA_WIDTH-1] ? (data_t'(0) - a_in) : a_in;
  assign b_mag = b_in[DATA_WIDTH-1] ? (data_t'(0) - b_in) : b_in;

  assign div_start = in_acc && (in_i.opcode != OP_POW) && (b_in != '0);

  idmp_div_core u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_mag),
    .divisor_i  (b_mag),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  idmp_mul_core u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (fac_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign expo_shr = expo_q >> 1;
  // Quotient sign is sign(a) ^ sign(b); remainder follows the dividend.
  assign neg_res  = (op_q == OP_QUO) ? (sa_q ^ sb_q) : sa_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    st_d        = st_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    rnz_d       = rnz_q;
    b_d         = b_q;
    res_d       = res_q;
    expo_d      = expo_q;
    pacc_d      = pacc_q;
    fac_d       = fac_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_st_d    = out_st_q;
    mul_start   = 1'b0;
    mul_a       = pacc_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d  = in_i.opcode;
          b_d   = b_in;
          sa_d  = a_in[DATA_WIDTH-1];
          sb_d  = b_in[DATA_WIDTH-1];
          res_d = '0;
          st_d  = ST_OK;
          if (in_i.opcode == OP_POW) begin
            if (b_in[DATA_WIDTH-1]) begin
              st_d    = ST_NEGEXP;
              state_d = S_DONE;
            end else begin
              pacc_d  = data_t'(1);
              fac_d   = a_in;
              expo_d  = b_in;
              state_d = S_PCHK;
            end
          end else if (b_in == '0) begin
            st_d    = ST_DIVZERO;
            state_d = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = (op_q == OP_QUO) ? div_quo : div_rem;
          rnz_d   = (div_rem != '0);
          state_d = S_NEG;
        end
      end
      S_NEG: begin
        if (neg_res) begin
          res_d = data_t'(0) - res_q;
        end
        // Modulo: nonzero remainder with mismatched signs moves by the divisor.
        if ((op_q == OP_MOD) && rnz_q && (sa_q != sb_q)) begin
          state_d = S_FIX;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FIX: begin
        res_d   = res_q + b_q;
        state_d = S_DONE;
      end
      S_PCHK: begin
        if (expo_q == '0) begin
          res_d   = pacc_q;
          state_d = S_DONE;
        end else if (expo_q[0]) begin
          mul_start = 1'b1;
          state_d   = S_PMUL;
        end else begin
          state_d = S_PSHIFT;
        end
      end
      S_PMUL: begin
        if (mul_done) begin
          pacc_d  = mul_prod;
          state_d = S_PSHIFT;
        end
      end
      S_PSHIFT: begin
        expo_d = expo_shr;
        if (expo_shr != '0) begin
          mul_a     = fac_q;
          mul_start = 1'b1;
          state_d   = S_PSQR;
        end else begin
          state_d = S_PCHK;
        end
      end
      S_PSQR: begin
        if (mul_done) begin
          fac_d   = mul_prod;
          state_d = S_PCHK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_res_d   = OPND_W'($signed(res_q));
          out_st_d    = st_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    st_q      <= st_d;
    sa_q      <= sa_d;
    sb_q      <= sb_d;
    rnz_q     <= rnz_d;
    b_q       <= b_d;
    res_q     <= res_d;
    expo_q    <= expo_d;
    pacc_q    <= pacc_d;
    fac_q     <= fac_d;
    out_res_q <= out_res_d;
    out_st_q  <= out_st_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status       = out_st_q;

endmodule

// ===== sv/idmp_div_core.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// Depends on idmp_pkg.
module idmp_div_core
  import idmp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  output logic  done_o,
  output data_t quo_o,
  output data_t rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  data_t              rem_q, rem_d;
  data_t              quo_q, quo_d;
  data_t              dvsr_q, dvsr_d;
  logic [DATA_WIDTH:0] shifted;
  logic [DATA_WIDTH:0] diff;
  logic               fits;

  assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr_q};
  assign fits    = !diff[DATA_WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvsr_d = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      quo_d = {quo_q[DATA_WIDTH-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvsr_q <= dvsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/idmp_mul_core.sv =====
`timescale 1ns / 1ps
// Wrapped DATA_WIDTH-bit multiply on one half-width multiplier, three partial
// products accumulated in turn. Depends on idmp_pkg.
module idmp_mul_core
  import idmp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t a_i,
  input  data_t b_i,
  output logic  done_o,
  output data_t prod_o
);

  localparam int HI_W = DATA_WIDTH - HALF_W;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [1:0]            cnt_q, cnt_d;
  data_t                 opa_q, opa_d;
  data_t                 opb_q, opb_d;
  data_t                 acc_q, acc_d;
  logic [2*HALF_W-1:0]   pp_q, pp_d;
  logic [HALF_W-1:0]     a_lo, a_hi, b_lo, b_hi;
  logic [HALF_W-1:0]     mul_x, mul_y;
  data_t                 pp_trunc;

  assign a_lo = opa_q[HALF_W-1:0];
  assign b_lo = opb_q[HALF_W-1:0];
  assign a_hi = HALF_W'(opa_q[DATA_WIDTH-1:HALF_W]);
  assign b_hi = HALF_W'(opb_q[DATA_WIDTH-1:HALF_W]);
  assign pp_trunc = DATA_WIDTH'(pp_q);

  // Partial product select: lo*lo, lo*hi, hi*lo (hi*hi falls off the top).
  always_comb begin
    case (cnt_q)
      2'd0:    begin mul_x = a_lo; mul_y = b_lo; end
      2'd1:    begin mul_x = a_lo; mul_y = b_hi; end
      default: begin mul_x = a_hi; mul_y = b_lo; end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    acc_d  = acc_q;
    pp_d   = pp_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      opa_d  = a_i;
      opb_d  = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      pp_d  = (2*HALF_W)'(mul_x) * (2*HALF_W)'(mul_y);
      cnt_d = cnt_q + 2'd1;
      case (cnt_q)
        2'd0:    acc_d = acc_q;
        2'd1:    acc_d = acc_q + pp_trunc;
        default: acc_d = acc_q + (pp_trunc << HALF_W);
      endcase
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    opb_q <= opb_d;
    acc_q <= acc_d;
    pp_q  <= pp_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

  // High halves are zero-extended to HALF_W, so HI_W must not exceed HALF_W.
  if (HI_W > HALF_W) begin : g_bad_split
    $error("multiplier split wider than half width");
  end

endmodule

// ===== sv/idmp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for int_divide_modulo_power_unit, attached by bind.
// Depends on idmp_pkg.
module idmp_checker
  import idmp_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic signed [OPND_W-1:0] out_result_value_i,
  input status_e                  out_status_i
);

  // Busy after an accepted beat: no second beat in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while busy");

  // Error results carry a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_status_i != ST_OK)) |-> (out_result_value_i == '0))
    else $error("nonzero result with error status");

  // With no result pending at an accept, none shows up in the cycle right after.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((in_valid_i && in_ready_i) && !out_valid_i) |=> !out_valid_i)
    else $error("result appeared without processing");

  // Stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_result_value_i) && $stable(out_status_i)))
    else $error("output beat changed under stall");

endmodule

bind int_divide_modulo_power_unit idmp_checker u_idmp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_result_value_i (out_o.result_value),
  .out_status_i       (out_o.status)
);
